// File: src/frame_staging_fifo_drop_on_full_macros.svh
// Assertion macros shared by the frame staging queue RTL.
`ifndef FRAME_STAGING_FIFO_DROP_ON_FULL_MACROS_SVH
`define FRAME_STAGING_FIFO_DROP_ON_FULL_MACROS_SVH

// Clocked check, suspended while reset is asserted.
`define FSF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define FSF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/fsf_pkg.sv
// Constants and types for the frame staging queue.
package fsf_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_BYTES = 2048;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int IDX_W  = SLOT_W + 1;
    localparam int BOFF_W = $clog2(SLOT_BYTES);
    localparam int OFF_W  = BOFF_W + 1;
    localparam int ADDR_W = SLOT_W + BOFF_W;
    localparam int DEPTH  = SLOT_COUNT * SLOT_BYTES;
    localparam int LEN_W  = 12;

    localparam logic [IDX_W-1:0] FULL_HELD = IDX_W'(SLOT_COUNT);
    localparam logic [OFF_W-1:0] OFF_MAX   = OFF_W'(SLOT_BYTES);

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_CLAMPED = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_STORE = 3'b010,
        MODE_DROP  = 3'b100
    } mode_t;

endpackage

// File: src/frame_staging_fifo_drop_on_full.sv
// Receive frame staging queue with drop on full: slot ring, byte store and result register.
`include "frame_staging_fifo_drop_on_full_macros.svh"

// The block takes one item in every cycle (busy is always low) and shows its result
// for exactly one cycle, marked by done, in the cycle after the item is accepted; the
// read of the byte store is registered. The receiver cannot stall, so a
// result must be taken in the cycle it is shown. frames_held and drop_count give the
// queue state after the item whose result is on the ports. A frame that starts while
// all slots hold closed frames is dropped whole; bytes past the slot size are
// discarded and the stored length stays clamped at the slot size.
module frame_staging_fifo_drop_on_full (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [7:0]  data,
    input  logic        frame_end,
    input  logic        no_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  read_byte,
    output logic        byte_valid,
    output logic        read_last,
    output logic [11:0] frame_length,
    output logic [3:0]  frames_held,
    output logic [31:0] drop_count
);

    logic [7:0]                   mem [fsf_pkg::DEPTH];
    logic [fsf_pkg::OFF_W-1:0]    len_mem [fsf_pkg::SLOT_COUNT];

    logic [fsf_pkg::IDX_W-1:0]    wi_reg, wi_next;
    logic [fsf_pkg::IDX_W-1:0]    ri_reg, ri_next;
    logic [fsf_pkg::OFF_W-1:0]    wo_reg, wo_next;
    logic [fsf_pkg::OFF_W-1:0]    ro_reg, ro_next;
    fsf_pkg::mode_t               mode_reg, mode_next, mode_cur;
    logic [31:0]                  drop_reg, drop_next;

    logic                         done_reg;
    logic [1:0]                   status_reg, status_next;
    logic                         valid_reg, valid_next;
    logic                         last_reg, last_next;
    logic [fsf_pkg::OFF_W-1:0]    flen_reg, flen_next;
    logic [7:0]                   rd_q;

    logic                         accept;
    logic [fsf_pkg::IDX_W-1:0]    held;
    logic [fsf_pkg::OFF_W-1:0]    rd_len;
    logic [fsf_pkg::OFF_W-1:0]    ro_inc;
    logic                         mem_we;
    logic                         mem_re;
    logic                         len_we;
    logic [fsf_pkg::ADDR_W-1:0]   waddr;
    logic [fsf_pkg::ADDR_W-1:0]   raddr;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign held   = wi_reg - ri_reg;
    assign rd_len = len_mem[ri_reg[fsf_pkg::SLOT_W-1:0]];
    assign ro_inc = ro_reg + 1'b1;
    assign waddr  = {wi_reg[fsf_pkg::SLOT_W-1:0], wo_reg[fsf_pkg::BOFF_W-1:0]};
    assign raddr  = {ri_reg[fsf_pkg::SLOT_W-1:0], ro_reg[fsf_pkg::BOFF_W-1:0]};

    always_comb
    begin
        wi_next     = wi_reg;
        ri_next     = ri_reg;
        wo_next     = wo_reg;
        ro_next     = ro_reg;
        mode_next   = mode_reg;
        mode_cur    = mode_reg;
        drop_next   = drop_reg;
        status_next = fsf_pkg::ST_OK;
        valid_next  = 1'b0;
        last_next   = 1'b0;
        flen_next   = '0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        len_we      = 1'b0;
        if (accept && opcode == fsf_pkg::OP_PUSH)
        begin
            // open a frame, or drop it whole when every slot is taken
            case (mode_reg)
                fsf_pkg::MODE_IDLE:
                begin
                    if (held == fsf_pkg::FULL_HELD)
                    begin
                        mode_cur  = fsf_pkg::MODE_DROP;
                        drop_next = drop_reg + 32'd1;
                    end
                    else
                    begin
                        mode_cur = fsf_pkg::MODE_STORE;
                        wo_next  = '0;
                    end
                end
                default:
                begin
                    mode_cur = mode_reg;
                end
            endcase
            mode_next = mode_cur;
            if (mode_cur == fsf_pkg::MODE_DROP)
            begin
                status_next = fsf_pkg::ST_DROPPED;
                if (frame_end)
                begin
                    mode_next = fsf_pkg::MODE_IDLE;
                end
            end
            else
            begin
                if (!no_data)
                begin
                    if (wo_next < fsf_pkg::OFF_MAX)
                    begin
                        mem_we  = 1'b1;
                        wo_next = wo_next + 1'b1;
                    end
                    else
                    begin
                        status_next = fsf_pkg::ST_CLAMPED;
                    end
                end
                flen_next = wo_next;
                if (frame_end)
                begin
                    len_we    = 1'b1;
                    wi_next   = wi_reg + 1'b1;
                    wo_next   = '0;
                    mode_next = fsf_pkg::MODE_IDLE;
                end
            end
        end
        else if (accept)
        begin
            if (held == '0)
            begin
                status_next = fsf_pkg::ST_EMPTY;
            end
            else
            begin
                flen_next = rd_len;
                if (ro_reg < rd_len)
                begin
                    mem_re     = 1'b1;
                    valid_next = 1'b1;
                    ro_next    = ro_inc;
                end
                // free the slot once its last byte is out
                if (ro_next >= rd_len)
                begin
                    last_next = 1'b1;
                    ro_next   = '0;
                    ri_next   = ri_reg + 1'b1;
                end
            end
        end
    end

    // Byte store and slot lengths: no reset, written before any read of the entry.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= data;
        end
        if (mem_re)
        begin
            rd_q <= mem[raddr];
        end
        if (len_we)
        begin
            len_mem[wi_reg[fsf_pkg::SLOT_W-1:0]] <= flen_next;
        end
        if (accept)
        begin
            status_reg <= status_next;
            valid_reg  <= valid_next;
            last_reg   <= last_next;
            flen_reg   <= flen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg   <= '0;
            ri_reg   <= '0;
            wo_reg   <= '0;
            ro_reg   <= '0;
            mode_reg <= fsf_pkg::MODE_IDLE;
            drop_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            wi_reg   <= wi_next;
            ri_reg   <= ri_next;
            wo_reg   <= wo_next;
            ro_reg   <= ro_next;
            mode_reg <= mode_next;
            drop_reg <= drop_next;
            done_reg <= accept;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign byte_valid   = valid_reg;
    assign read_last    = last_reg;
    assign read_byte    = valid_reg ? rd_q : 8'd0;
    assign frame_length = (fsf_pkg::LEN_W)'(flen_reg);
    assign frames_held  = 4'(held);
    assign drop_count   = drop_reg;

    `FSF_ASSERT(a_held_bound, held <= fsf_pkg::FULL_HELD, "queue holds more frames than slots")
    `FSF_ASSERT(a_wo_bound, wo_reg <= fsf_pkg::OFF_MAX, "write offset beyond slot size")
    `FSF_ASSERT(a_done_follows, done |-> $past(accept), "result without an accepted item")
    `FSF_ASSERT(a_last_ok, done && read_last |-> status == fsf_pkg::ST_OK, "slot freed with bad status")
    `FSF_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !done, "result shown out of reset")

endmodule

// File: dv/frame_staging_checker.sv
`timescale 1ns / 1ps
// Frame staging queue checker: predicts every result and compares it with the block's output.
module frame_staging_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        opcode,
    input  logic [7:0]  data,
    input  logic        frame_end,
    input  logic        no_data,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [7:0]  read_byte,
    input  logic        byte_valid,
    input  logic        read_last,
    input  logic [11:0] frame_length,
    input  logic [3:0]  frames_held,
    input  logic [31:0] drop_count,
    output int          fail_count,
    output int          outstanding
);

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  read_byte;
        logic        byte_valid;
        logic        read_last;
        logic [11:0] frame_length;
        logic [3:0]  frames_held;
        logic [31:0] drop_count;
    } frame_result_t;

    logic [7:0]                slot_mem [fsf_pkg::DEPTH];
    logic [fsf_pkg::LEN_W-1:0] slot_len [fsf_pkg::SLOT_COUNT];
    logic [fsf_pkg::IDX_W-1:0] wr_idx;
    logic [fsf_pkg::IDX_W-1:0] rd_idx;
    logic [fsf_pkg::OFF_W-1:0] wr_off;
    logic [fsf_pkg::OFF_W-1:0] rd_off;
    fsf_pkg::mode_t            push_mode;
    logic [31:0]               drops;
    frame_result_t             expected_results [$];
    int                        result_num;
    int                        mismatches;

    assign fail_count = mismatches;

    // Apply one item to the predicted queue and return the result it should give.
    function automatic frame_result_t stage_item(input logic op, input logic [7:0] d,
                                                 input logic fe, input logic nd);
        frame_result_t             r;
        logic [fsf_pkg::IDX_W-1:0] held;
        logic [fsf_pkg::LEN_W-1:0] len;
        r = '0;
        held = wr_idx - rd_idx;
        if (op == fsf_pkg::OP_PUSH)
        begin
            // A new frame opens here; drop it whole if every slot holds a closed frame.
            if (push_mode != fsf_pkg::MODE_STORE && push_mode != fsf_pkg::MODE_DROP)
            begin
                if (held >= fsf_pkg::FULL_HELD)
                begin
                    push_mode = fsf_pkg::MODE_DROP;
                    drops = drops + 32'd1;
                end
                else
                begin
                    push_mode = fsf_pkg::MODE_STORE;
                    wr_off = '0;
                end
            end
            if (push_mode == fsf_pkg::MODE_DROP)
            begin
                r.status = fsf_pkg::ST_DROPPED;
                if (fe)
                    push_mode = fsf_pkg::MODE_IDLE;
            end
            else
            begin
                if (!nd)
                begin
                    if (wr_off < fsf_pkg::OFF_MAX)
                    begin
                        slot_mem[{wr_idx[fsf_pkg::SLOT_W-1:0],
                                  wr_off[fsf_pkg::BOFF_W-1:0]}] = d;
                        wr_off = wr_off + 1'b1;
                    end
                    else
                        r.status = fsf_pkg::ST_CLAMPED;
                end
                r.frame_length = wr_off;
                if (fe)
                begin
                    slot_len[wr_idx[fsf_pkg::SLOT_W-1:0]] = wr_off;
                    wr_idx = wr_idx + 1'b1;
                    wr_off = '0;
                    push_mode = fsf_pkg::MODE_IDLE;
                end
            end
        end
        else if (held == '0)
            r.status = fsf_pkg::ST_EMPTY;
        else
        begin
            len = slot_len[rd_idx[fsf_pkg::SLOT_W-1:0]];
            r.frame_length = len;
            if (len != '0 && rd_off < len)
            begin
                r.read_byte = slot_mem[{rd_idx[fsf_pkg::SLOT_W-1:0],
                                        rd_off[fsf_pkg::BOFF_W-1:0]}];
                r.byte_valid = 1'b1;
                rd_off = rd_off + 1'b1;
            end
            // Free the slot after its last byte.
            if (rd_off >= len)
            begin
                r.read_last = 1'b1;
                rd_off = '0;
                rd_idx = rd_idx + 1'b1;
            end
        end
        r.frames_held = wr_idx - rd_idx;
        r.drop_count = drops;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_result_t want;
        frame_result_t got;
        if (!rst_n)
        begin
            wr_idx = '0;
            rd_idx = '0;
            wr_off = '0;
            rd_off = '0;
            push_mode = fsf_pkg::MODE_IDLE;
            drops = '0;
            expected_results.delete();
            result_num = 0;
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            // Queue the new item first so a same-cycle result still finds its expectation.
            if (start && !busy)
                expected_results.push_back(stage_item(opcode, data, frame_end, no_data));
            if (done)
            begin
                got = {status, read_byte, byte_valid, read_last, frame_length, frames_held,
                       drop_count};
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("Result %0d arrived with no item outstanding", result_num);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got != want)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("Result %0d mismatch: expected status %0d byte %02h valid %0b last %0b len %0d held %0d drops %0d",
                                     result_num, want.status, want.read_byte, want.byte_valid,
                                     want.read_last, want.frame_length, want.frames_held,
                                     want.drop_count);
                            $display("Result %0d mismatch: got status %0d byte %02h valid %0b last %0b len %0d held %0d drops %0d",
                                     result_num, got.status, got.read_byte, got.byte_valid,
                                     got.read_last, got.frame_length, got.frames_held,
                                     got.drop_count);
                        end
                        mismatches++;
                    end
                end
                result_num++;
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the frame staging queue: clock, reset, item stimulus and verdict.
module testbench;

    localparam int RANDOM_ITEMS = 550;
    localparam int STALL_LIMIT  = 1000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        opcode;
    logic [7:0]  data;
    logic        frame_end;
    logic        no_data;
    logic        done;
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic        byte_valid;
    logic        read_last;
    logic [11:0] frame_length;
    logic [3:0]  frames_held;
    logic [31:0] drop_count;

    int check_fails;
    int outstanding;
    int idle_pct;
    int items_sent;
    int stall_cycles;

    frame_staging_fifo_drop_on_full uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .data         (data),
        .frame_end    (frame_end),
        .no_data      (no_data),
        .done         (done),
        .status       (status),
        .read_byte    (read_byte),
        .byte_valid   (byte_valid),
        .read_last    (read_last),
        .frame_length (frame_length),
        .frames_held  (frames_held),
        .drop_count   (drop_count)
    );

    frame_staging_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .data         (data),
        .frame_end    (frame_end),
        .no_data      (no_data),
        .done         (done),
        .status       (status),
        .read_byte    (read_byte),
        .byte_valid   (byte_valid),
        .read_last    (read_last),
        .frame_length (frame_length),
        .frames_held  (frames_held),
        .drop_count   (drop_count),
        .fail_count   (check_fails),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Count cycles in which neither an item nor a result moves.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        stall_cycles = 0;
        wait (stall_cycles >= STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Hold off a random number of cycles, then present one item until it is taken.
    task automatic send_item(input logic op, input logic [7:0] d, input logic fe,
                             input logic nd);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            data  <= 8'($urandom);
            @(posedge clk);
        end
        start     <= 1'b1;
        opcode    <= op;
        data      <= d;
        frame_end <= fe;
        no_data   <= nd;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    task automatic push_byte(input logic [7:0] d, input logic fe);
        send_item(fsf_pkg::OP_PUSH, d, fe, 1'b0);
    endtask

    // Pop with random don't-care fields.
    task automatic pop_byte();
        send_item(fsf_pkg::OP_POP, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Push one well-formed frame, with stray empty pushes and pops mixed in.
    task automatic push_frame(input int len);
        bit close_empty;
        close_empty = (len == 0) || ($urandom_range(99) < 15);
        if (len == 0 && $urandom_range(1) == 1)
            send_item(fsf_pkg::OP_PUSH, 8'($urandom), 1'b0, 1'b1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 8)
                pop_byte();
            if ($urandom_range(99) < 6)
                send_item(fsf_pkg::OP_PUSH, 8'($urandom), 1'b0, 1'b1);
            push_byte(8'($urandom), !close_empty && i == len - 1);
        end
        if (close_empty)
            send_item(fsf_pkg::OP_PUSH, 8'($urandom), 1'b1, 1'b1);
    endtask

    initial
    begin
        int random_base;
        int phase;
        int cur_phase;
        int pop_pct;
        int burst_mark;
        start      = 1'b0;
        opcode     = fsf_pkg::OP_PUSH;
        data       = 8'h00;
        frame_end  = 1'b0;
        no_data    = 1'b0;
        idle_pct   = 0;
        items_sent = 0;
        rst_n      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pop_byte();
        send_item(fsf_pkg::OP_PUSH, 8'h00, 1'b0, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        // Keep the next frame open while the closed one is read out.
        push_byte(8'h5A, 1'b0);
        repeat (3) pop_byte();
        push_byte(8'hC3, 1'b1);
        // Fill the ring with zero-length frames, then drop a frame and an empty one.
        repeat (7) send_item(fsf_pkg::OP_PUSH, 8'hFF, 1'b1, 1'b1);
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b1);
        send_item(fsf_pkg::OP_PUSH, 8'h33, 1'b1, 1'b1);
        repeat (10) pop_byte();

        // One oversized frame: clamp the tail bytes, then read back the full slot.
        for (int i = 0; i < fsf_pkg::SLOT_BYTES + 2; i++)
            push_byte(8'($urandom), i == fsf_pkg::SLOT_BYTES + 1);
        repeat (fsf_pkg::SLOT_BYTES + 1) pop_byte();
        wait_drained();

        random_base = items_sent;
        cur_phase   = 0;
        pop_pct     = 40;
        burst_mark  = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS)
        begin
            phase = (items_sent - random_base) * 4 / RANDOM_ITEMS;
            if (phase != cur_phase)
            begin
                wait_drained();
                cur_phase = phase;
                idle_pct  = (phase == 1) ? 59 : (phase == 3) ? 6 : 0;
            end
            // Pick at random, for each burst, between filling and emptying the ring.
            if (items_sent - burst_mark >= 60)
            begin
                pop_pct    = ($urandom_range(1) == 1) ? 25 : 65;
                burst_mark = items_sent;
            end
            if ($urandom_range(99) < 6)
                send_item(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            else if ($urandom_range(99) < pop_pct)
                repeat ($urandom_range(1, 12)) pop_byte();
            else if ($urandom_range(99) < 75)
                push_frame($urandom_range(0, 6));
            else
                push_frame($urandom_range(7, 40));
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (check_fails == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: frame_staging_fifo_drop_on_full.f
+incdir+src
src/fsf_pkg.sv
src/frame_staging_fifo_drop_on_full.sv
dv/frame_staging_checker.sv
dv/testbench.sv
